// ----- rtl/core/bleasd_pkg.sv -----
// Shared types and constants for the advertising sensor decoder.
`default_nettype none

package bleasd_pkg;

   // Kind of the length-type-value field being walked.
   typedef enum logic [1:0] {
      KIND_OTHER     = 2'd0,
      KIND_NAME      = 2'd1,
      KIND_MFG       = 2'd2,
      KIND_TYPE_NEXT = 2'd3
   } field_kind_type;

   // AD type codes of interest.
   localparam logic [7:0] AD_TYPE_SHORT_NAME    = 8'h08;
   localparam logic [7:0] AD_TYPE_COMPLETE_NAME = 8'h09;
   localparam logic [7:0] AD_TYPE_MFG_DATA      = 8'hFF;

   // Manufacturer field needs this many data bytes to carry a reading.
   localparam logic [7:0] MIN_MFG_DATA = 8'd4;

   // Model-name pattern searched for in the local name.
   localparam logic [2:0] PATTERN_LEN = 3'd5;

   // Manufacturer data byte positions.
   localparam logic [7:0] POS_TEMP_LO  = 8'd1;
   localparam logic [7:0] POS_TEMP_HI  = 8'd2;
   localparam logic [7:0] POS_HUMIDITY = 8'd3;

   // Result packing.
   localparam int TEMP_W    = 16;
   localparam int HUMID_W   = 8;
   localparam int RSP_W     = 32;
   localparam int RSP_VALID = TEMP_W + HUMID_W;
   localparam int RSP_MATCH = RSP_VALID + 1;

   function automatic logic [7:0] pattern_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h54;
         3'd1:    val = 8'h50;
         3'd2:    val = 8'h33;
         3'd3:    val = 8'h35;
         3'd4:    val = 8'h37;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ble_adv_sensor_decoder.sv -----
// Top level of the advertising payload decoder: LTV walk, name search, sensor reading.
//
// Feed the bytes of one advertising payload on the req_ channel, one byte per
// transaction, with req_tlast set on the final byte. The block walks the
// length-type-value fields, stops at a zero length byte, remembers whether the
// last complete local-name field holds the model-name pattern, and takes the
// temperature (data bytes 1 and 2, little-endian, signed tenths of a degree)
// and humidity (data byte 3) from the last complete manufacturer field with at
// least four data bytes. Fields cut short by the end of the payload are
// ignored. Exactly one result transaction leaves on rsp_ for each payload,
// from a register loaded when its final byte is taken, and all parse state
// then clears. The block takes one byte per clock: each accepted byte updates
// the field walker registers, and the result sits in one output register.
// Non-final bytes keep flowing while a result waits on rsp_tready; a final
// byte waits only until the output register is free. No reset sweep: the
// block is ready as soon as reset is released.
`default_nettype none

module ble_adv_sensor_decoder (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ad_byte
   input  wire logic        req_tlast,   // last_byte

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // [15:0] temperature_tenths, [23:16] humidity_percent,
                                         // [24] reading_valid, [25] name_match, [31:26] zero
);

   import bleasd_pkg::*;

   // Field walker state.
   logic [7:0]         bytes_left_ff,   bytes_left_in;
   field_kind_type     kind_ff,         kind_in;
   logic [7:0]         data_pos_ff,     data_pos_in;
   logic [7:0]         data_len_ff,     data_len_in;
   logic               stopped_ff,      stopped_in;
   logic [TEMP_W-1:0]  pend_temp_ff,    pend_temp_in;
   logic [HUMID_W-1:0] pend_humid_ff,   pend_humid_in;
   logic [TEMP_W-1:0]  held_temp_ff,    held_temp_in;
   logic [HUMID_W-1:0] held_humid_ff,   held_humid_in;
   logic               held_valid_ff,   held_valid_in;
   logic [2:0]         match_prog_ff,   match_prog_in;
   logic               field_match_ff,  field_match_in;
   logic               held_match_ff,   held_match_in;

   // Result register.
   logic               rsp_valid_ff,    rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff,     rsp_data_in;

   logic               req_accept;
   logic [7:0]         in_byte;

   assign in_byte    = req_tdata;
   // Hold a final byte only while an untaken result occupies the output register.
   assign req_tready = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      kind_in        = kind_ff;
      data_pos_in    = data_pos_ff;
      data_len_in    = data_len_ff;
      stopped_in     = stopped_ff;
      pend_temp_in   = pend_temp_ff;
      pend_humid_in  = pend_humid_ff;
      held_temp_in   = held_temp_ff;
      held_humid_in  = held_humid_ff;
      held_valid_in  = held_valid_ff;
      match_prog_in  = match_prog_ff;
      field_match_in = field_match_ff;
      held_match_in  = held_match_ff;
      rsp_data_in    = rsp_data_ff;

      if (req_accept && !stopped_ff) begin
         if (bytes_left_ff == 8'd0) begin
            // Length byte: zero ends the walk, anything else opens a field.
            if (in_byte == 8'd0) begin
               stopped_in = 1'b1;
            end else begin
               bytes_left_in  = in_byte;
               data_len_in    = in_byte - 8'd1;
               data_pos_in    = 8'd0;
               kind_in        = KIND_TYPE_NEXT;
               match_prog_in  = 3'd0;
               field_match_in = 1'b0;
            end
         end else begin
            if (kind_ff == KIND_TYPE_NEXT) begin
               if (in_byte == AD_TYPE_SHORT_NAME || in_byte == AD_TYPE_COMPLETE_NAME) begin
                  kind_in = KIND_NAME;
               end else if (in_byte == AD_TYPE_MFG_DATA) begin
                  kind_in = KIND_MFG;
               end else begin
                  kind_in = KIND_OTHER;
               end
            end else begin
               case (kind_ff)
                  KIND_NAME: begin
                     if (!field_match_ff) begin
                        // Pattern has no repeated prefix: a miss restarts at its first byte.
                        if (match_prog_ff < PATTERN_LEN &&
                            in_byte == pattern_byte(match_prog_ff)) begin
                           match_prog_in = match_prog_ff + 3'd1;
                        end else if (in_byte == pattern_byte(3'd0)) begin
                           match_prog_in = 3'd1;
                        end else begin
                           match_prog_in = 3'd0;
                        end
                        if (match_prog_in >= PATTERN_LEN) begin
                           field_match_in = 1'b1;
                        end
                     end
                  end
                  KIND_MFG: begin
                     if (data_pos_ff == POS_TEMP_LO) begin
                        pend_temp_in = {pend_temp_ff[15:8], in_byte};
                     end else if (data_pos_ff == POS_TEMP_HI) begin
                        pend_temp_in = {in_byte, pend_temp_ff[7:0]};
                     end else if (data_pos_ff == POS_HUMIDITY) begin
                        pend_humid_in = in_byte;
                     end
                  end
                  default: begin
                  end
               endcase
               // Saturate the data index.
               if (data_pos_ff != 8'hFF) begin
                  data_pos_in = data_pos_ff + 8'd1;
               end
            end

            bytes_left_in = bytes_left_ff - 8'd1;

            // Last byte of a complete field: commit its name result or reading.
            if (bytes_left_ff == 8'd1) begin
               if (kind_in == KIND_NAME) begin
                  held_match_in = field_match_in;
               end else if (kind_in == KIND_MFG && data_len_ff >= MIN_MFG_DATA) begin
                  held_temp_in  = pend_temp_in;
                  held_humid_in = pend_humid_in;
                  held_valid_in = 1'b1;
               end
            end
         end
      end

      if (req_accept && req_tlast) begin
         rsp_data_in = '0;
         if (held_valid_in) begin
            rsp_data_in[TEMP_W-1:0]              = held_temp_in;
            rsp_data_in[RSP_VALID-1:TEMP_W]      = held_humid_in;
            rsp_data_in[RSP_VALID]               = 1'b1;
         end
         rsp_data_in[RSP_MATCH] = held_match_in;

         // Clear all parse state for the next payload.
         bytes_left_in  = 8'd0;
         kind_in        = KIND_OTHER;
         data_pos_in    = 8'd0;
         data_len_in    = 8'd0;
         stopped_in     = 1'b0;
         pend_temp_in   = '0;
         pend_humid_in  = '0;
         held_temp_in   = '0;
         held_humid_in  = '0;
         held_valid_in  = 1'b0;
         match_prog_in  = 3'd0;
         field_match_in = 1'b0;
         held_match_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= 8'd0;
         kind_ff        <= KIND_OTHER;
         data_pos_ff    <= 8'd0;
         data_len_ff    <= 8'd0;
         stopped_ff     <= 1'b0;
         pend_temp_ff   <= '0;
         pend_humid_ff  <= '0;
         held_temp_ff   <= '0;
         held_humid_ff  <= '0;
         held_valid_ff  <= 1'b0;
         match_prog_ff  <= 3'd0;
         field_match_ff <= 1'b0;
         held_match_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bytes_left_ff  <= bytes_left_in;
         kind_ff        <= kind_in;
         data_pos_ff    <= data_pos_in;
         data_len_ff    <= data_len_in;
         stopped_ff     <= stopped_in;
         pend_temp_ff   <= pend_temp_in;
         pend_humid_ff  <= pend_humid_in;
         held_temp_ff   <= held_temp_in;
         held_humid_ff  <= held_humid_in;
         held_valid_ff  <= held_valid_in;
         match_prog_ff  <= match_prog_in;
         field_match_ff <= field_match_in;
         held_match_ff  <= held_match_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload register: no reset needed.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // A final byte always produces a result in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   // Parse state is clear after a final byte.
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> bytes_left_ff == 8'd0 && !stopped_ff && !held_valid_ff
                                  && !held_match_ff)
      else $error("parse state not cleared after final byte");

   // Without a reading, temperature and humidity read zero.
   a_no_reading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[RSP_VALID] |-> rsp_data_ff[RSP_VALID-1:0] == '0)
      else $error("reading fields nonzero without a valid reading");

   // A matched name field has seen the whole pattern.
   a_match_progress: assert property (@(posedge clock) disable iff (reset)
      field_match_ff |-> match_prog_ff == PATTERN_LEN)
      else $error("name match flagged without full pattern");

endmodule

`default_nettype wire

// ----- sim/ble_adv_sensor_decoder_tb.sv -----
// Self-checking testbench for the advertising payload sensor decoder.
`default_nettype none

module ble_adv_sensor_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bleasd_pkg::*;

   localparam int HOLD_CYCLES    = 400;   // long output hold in the backpressure phase
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
   localparam int PHASE_ITEMS    = 270;   // least number of bytes per random traffic phase
   localparam int MAX_REPORTS    = 10;

   // Model-name pattern, first character in the lowest byte.
   localparam logic [39:0] NAME_PATTERN = 40'h37_35_33_50_54;

   // Traffic shapes applied one after another to the random stimulus.
   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE,
      PH_COUNT
   } traffic_phase_type;

   // Field walker state, mirrored from the block's behavior.
   typedef struct packed {
      logic [7:0]     bytes_left;
      field_kind_type kind;
      logic [7:0]     data_pos;
      logic [7:0]     data_len;
      logic           stopped;
      logic [15:0]    pend_temp;
      logic [7:0]     pend_humid;
      logic [15:0]    held_temp;
      logic [7:0]     held_humid;
      logic           held_valid;
      logic [2:0]     match_pos;
      logic           name_hit;
      logic           held_match;
   } adv_walk_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [7:0]         humid;
      logic               valid;
      logic               match;
   } sensor_reading_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } adv_byte_type;

   // Every block input holds a known value from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] ad_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [15:0] temperature, [23:16] humidity,
                                      // [24] reading_valid, [25] name_match

   adv_walk_type       walk = '0;
   adv_byte_type       byte_backlog[$];       // bytes waiting for the driver
   sensor_reading_type expected_readings[$];  // predicted results, oldest first
   logic [7:0]         payload_buf[$];        // payload under construction

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rx_hold_left   = 0;
   int quiet_cycles   = 0;
   int n_pushed       = 0;
   int n_accepted     = 0;
   int n_payloads     = 0;
   int n_results      = 0;
   int n_valid        = 0;
   int n_named        = 0;
   int n_errors       = 0;

   ble_adv_sensor_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Append one byte to the payload under construction.
   function automatic void add_byte(input logic [7:0] b);
      payload_buf.insert(payload_buf.size(), b);
   endfunction

   // Advance the walker by one accepted byte; on the final byte queue the
   // reading that the block must return and clear the walker.
   function automatic void decode_adv_byte(input logic [7:0] b, input logic last);
      sensor_reading_type got;
      if (!walk.stopped) begin
         if (walk.bytes_left == 8'd0) begin
            // Length byte: zero ends the walk for the rest of this payload.
            if (b == 8'h00) begin
               walk.stopped = 1'b1;
            end else begin
               walk.bytes_left = b;
               walk.data_len   = b - 8'd1;
               walk.data_pos   = 8'd0;
               walk.kind       = KIND_TYPE_NEXT;
               walk.match_pos  = 3'd0;
               walk.name_hit   = 1'b0;
            end
         end else begin
            if (walk.kind == KIND_TYPE_NEXT) begin
               if (b == AD_TYPE_SHORT_NAME || b == AD_TYPE_COMPLETE_NAME) begin
                  walk.kind = KIND_NAME;
               end else if (b == AD_TYPE_MFG_DATA) begin
                  walk.kind = KIND_MFG;
               end else begin
                  walk.kind = KIND_OTHER;
               end
            end else begin
               if (walk.kind == KIND_NAME && !walk.name_hit) begin
                  // No repeated prefix in the pattern, so a miss restarts the search.
                  if (walk.match_pos < PATTERN_LEN && b == NAME_PATTERN[8*walk.match_pos +: 8])
                     walk.match_pos = walk.match_pos + 3'd1;
                  else
                     walk.match_pos = (b == NAME_PATTERN[7:0]) ? 3'd1 : 3'd0;
                  if (walk.match_pos >= PATTERN_LEN)
                     walk.name_hit = 1'b1;
               end else if (walk.kind == KIND_MFG) begin
                  if (walk.data_pos == POS_TEMP_LO)
                     walk.pend_temp[7:0] = b;
                  else if (walk.data_pos == POS_TEMP_HI)
                     walk.pend_temp[15:8] = b;
                  else if (walk.data_pos == POS_HUMIDITY)
                     walk.pend_humid = b;
               end
               if (walk.data_pos != 8'hFF)
                  walk.data_pos = walk.data_pos + 8'd1;
            end
            walk.bytes_left = walk.bytes_left - 8'd1;
            // Only a complete field updates the held values.
            if (walk.bytes_left == 8'd0) begin
               if (walk.kind == KIND_NAME) begin
                  walk.held_match = walk.name_hit;
               end else if (walk.kind == KIND_MFG && walk.data_len >= MIN_MFG_DATA) begin
                  walk.held_temp  = walk.pend_temp;
                  walk.held_humid = walk.pend_humid;
                  walk.held_valid = 1'b1;
               end
            end
         end
      end
      if (last) begin
         got.valid = walk.held_valid;
         got.temp  = walk.held_valid ? walk.held_temp : 16'sd0;
         got.humid = walk.held_valid ? walk.held_humid : 8'd0;
         got.match = walk.held_match;
         expected_readings.insert(expected_readings.size(), got);
         walk = '0;
      end
   endfunction

   // Move the payload under construction to the driver, flagging its last byte.
   task automatic send_payload();
      adv_byte_type item;
      int           i;
      for (i = 0; i < payload_buf.size(); i++) begin
         item.data = payload_buf[i];
         item.last = (i == payload_buf.size() - 1);
         byte_backlog.insert(byte_backlog.size(), item);
      end
      n_pushed   += payload_buf.size();
      n_payloads += 1;
   endtask

   // Hold the sender until every offered byte is taken and every reading is back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (n_accepted != n_pushed || expected_readings.size() != 0);
   endtask

   // Request driver: keep an offered byte steady until its transaction
   // completes, predict on each accepted byte, then either offer the next
   // byte or idle according to the current phase.
   always @(posedge clock) begin : drive_req
      adv_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         walk = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_adv_byte(req_tdata, req_tlast);
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = byte_backlog.pop_front();
               req_tdata  <= item.data;
               req_tlast  <= item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Count down the long output hold in a process of its own.
   always @(posedge clock) begin : count_hold
      if (rx_hold_left != 0)
         rx_hold_left <= rx_hold_left - 1;
   end

   // Result monitor: compare each result transaction with the oldest prediction,
   // then pick the next ready level (random stalls, or low during a long hold).
   always @(posedge clock) begin : watch_rsp
      sensor_reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_readings.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("unexpected result transaction: data %h", rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               n_valid += want.valid;
               n_named += want.match;
               if (rsp_tdata[TEMP_W-1:0] !== want.temp ||
                   rsp_tdata[RSP_VALID-1:TEMP_W] !== want.humid ||
                   rsp_tdata[RSP_VALID] !== want.valid ||
                   rsp_tdata[RSP_MATCH] !== want.match ||
                   rsp_tdata[RSP_W-1:RSP_MATCH+1] !== '0) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS)
                     $display({"reading %0d: expected temp %0d humid %0d valid %b match %b,",
                               " got temp %0d humid %0d valid %b match %b pad %h"},
                              n_results, want.temp, want.humid, want.valid, want.match,
                              $signed(rsp_tdata[TEMP_W-1:0]), rsp_tdata[RSP_VALID-1:TEMP_W],
                              rsp_tdata[RSP_VALID], rsp_tdata[RSP_MATCH],
                              rsp_tdata[RSP_W-1:RSP_MATCH+1]);
               end
            end
         end
         rsp_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no transaction moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed payloads first, then random payloads under each
   // traffic shape. The stimulus sets the phase settings only at the falling edge.
   initial begin : stimulus
      traffic_phase_type phase;
      int                n_fields, n, len, cut, off, roll, i, j, k;
      int                phase_items;
      logic [7:0]        kind_byte;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Name holding the pattern, then a reading with the most negative
      // temperature and full-scale humidity.
      payload_buf = '{8'h06, AD_TYPE_COMPLETE_NAME, 8'h54, 8'h50, 8'h33, 8'h35, 8'h37,
                      8'h05, AD_TYPE_MFG_DATA, 8'h00, 8'h00, 8'h80, 8'hFF};
      send_payload();
      // A lone zero length byte: no reading at all.
      payload_buf = '{8'h00};
      send_payload();
      // Manufacturer field cut short by the end of the payload.
      payload_buf = '{8'h03, AD_TYPE_MFG_DATA, 8'h7F};
      send_payload();
      // Short manufacturer field, empty name, zero length, then an ignored byte.
      payload_buf = '{8'h04, AD_TYPE_MFG_DATA, 8'h12, 8'h34, 8'h56,
                      8'h01, AD_TYPE_SHORT_NAME, 8'h00, 8'hAA};
      send_payload();

      for (i = 0; i < PH_COUNT; i++) begin
         phase = traffic_phase_type'(i);
         wait_drained();
         case (phase)
            PH_STEADY: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            PH_SENDER_IDLE: begin
               send_idle_pct  = 83;
               recv_stall_pct = 0;
            end
            PH_RECEIVER_STALL: begin
               send_idle_pct  = 0;
               recv_stall_pct = 83;
            end
            PH_BOTH_IDLE: begin
               send_idle_pct  = 19;
               recv_stall_pct = 19;
            end
            default: begin
               // Hold the output off while bytes keep coming, so a final byte
               // backs up behind the unread result.
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               rx_hold_left   = HOLD_CYCLES;
            end
         endcase

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            payload_buf.delete();
            n_fields = $urandom_range(0, 4);
            for (k = 0; k < n_fields; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 35) begin
                  // Local name, often holding the pattern or a near miss.
                  n = $urandom_range(0, 10);
                  add_byte(8'(n + 1));
                  add_byte(($urandom_range(0, 1) != 0) ? AD_TYPE_COMPLETE_NAME
                                                       : AD_TYPE_SHORT_NAME);
                  off = payload_buf.size();
                  for (j = 0; j < n; j++) begin
                     len = $urandom_range(0, 4);
                     add_byte(($urandom_range(0, 2) == 0) ? NAME_PATTERN[8*len +: 8]
                                                          : 8'($urandom));
                  end
                  if (n >= PATTERN_LEN && $urandom_range(0, 1) != 0) begin
                     j = off + $urandom_range(0, n - PATTERN_LEN);
                     for (len = 0; len < PATTERN_LEN; len++)
                        payload_buf[j + len] = NAME_PATTERN[8*len +: 8];
                     if ($urandom_range(0, 3) == 0) begin
                        j = j + $urandom_range(0, PATTERN_LEN - 1);
                        payload_buf[j] = payload_buf[j] ^ 8'h01;
                     end
                  end
               end else if (roll < 70) begin
                  // Manufacturer data, mostly long enough to carry a reading.
                  n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
                  add_byte(8'(n + 1));
                  add_byte(AD_TYPE_MFG_DATA);
                  for (j = 0; j < n; j++)
                     add_byte(8'($urandom));
               end else begin
                  // Any other type byte.
                  n = $urandom_range(0, 6);
                  add_byte(8'(n + 1));
                  add_byte(8'($urandom));
                  for (j = 0; j < n; j++)
                     add_byte(8'($urandom));
               end
            end

            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               // Zero length, then junk that must be ignored.
               add_byte(8'h00);
               n = $urandom_range(0, 3);
               for (j = 0; j < n; j++)
                  add_byte(8'($urandom));
            end else if (roll < 30) begin
               // Field cut short, possibly right after its length byte.
               len = $urandom_range(2, 255);
               cut = $urandom_range(0, (len - 1 < 10) ? len - 1 : 10);
               case ($urandom_range(0, 2))
                  0:       kind_byte = AD_TYPE_MFG_DATA;
                  1:       kind_byte = AD_TYPE_COMPLETE_NAME;
                  default: kind_byte = 8'($urandom);
               endcase
               add_byte(8'(len));
               for (j = 0; j < cut; j++) begin
                  if (j == 0)
                     add_byte(kind_byte);
                  else if (kind_byte == AD_TYPE_COMPLETE_NAME)
                     add_byte(NAME_PATTERN[8*((j - 1) % PATTERN_LEN) +: 8]);
                  else
                     add_byte(8'($urandom));
               end
            end else if (roll < 38) begin
               // Trailing noise.
               n = $urandom_range(1, 12);
               for (j = 0; j < n; j++)
                  add_byte(8'($urandom));
            end
            if (payload_buf.size() == 0)
               add_byte(8'($urandom));
            phase_items += payload_buf.size();
            send_payload();
         end
      end

      wait_drained();
      repeat (10) @(negedge clock);
      n_errors += expected_readings.size();

      $display("run covered %0d payloads, %0d bytes, %0d results (%0d with a reading, %0d name hits)",
               n_payloads, n_accepted, n_results, n_valid, n_named);
      $display({"traffic: steady, sender idle, receiver stall, both idle,",
                " %0d-cycle output hold; %0d failed checks"},
               HOLD_CYCLES, n_errors);
      if (n_errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
